// File: design/cartridge_bank_switch_mapper_defines.svh
// Assertion helpers for the cartridge mapper.
// Both expect clk and rst_n in the scope where they are used.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_DEFINES_SVH

// same-cycle implication
`define CBSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cbsm_pkg.sv
package cbsm_pkg;

  localparam int ROM_ADDR_BITS_DEF = 16;
  localparam int RAM_BYTES_DEF     = 2048;
  localparam int SLOT_COUNT_DEF    = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BANK_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_RAM = 2'd1;

  localparam logic [3:0] MODE_2K      = 4'd0;
  localparam logic [3:0] MODE_4K      = 4'd1;
  localparam logic [3:0] MODE_8K      = 4'd2;
  localparam logic [3:0] MODE_12K     = 4'd3;
  localparam logic [3:0] MODE_16K     = 4'd4;
  localparam logic [3:0] MODE_32K     = 4'd5;
  localparam logic [3:0] MODE_DELAYED = 4'd6;
  localparam logic [3:0] MODE_QUAD1K  = 4'd7;
  localparam logic [3:0] MODE_DATA2K  = 4'd8;
  localparam logic [3:0] MODE_TWOBANK = 4'd9;
  localparam logic [3:0] MODE_RAM2K   = 4'd10;
  localparam logic [3:0] MODE_COUNTER = 4'd11;
  localparam logic [3:0] MODE_RAM1K   = 4'd12;

  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_ROM_RD  = 3'd1;
  localparam logic [2:0] TGT_RAM_RD  = 3'd2;
  localparam logic [2:0] TGT_RAM_WR  = 3'd3;
  localparam logic [2:0] TGT_COUNTER = 3'd4;

  localparam logic [2:0] RAM_PAGE_START = 3'd4;

  typedef struct packed {
    logic [12:0] address;
    logic        is_write;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [15:0] target_offset;
    logic [3:0]  counter_value;
  } out_t;

  // slot base loaded on reset and on every mode write
  function automatic logic [15:0] mode_init(input logic [3:0] mode);
    logic [15:0] base;
    unique case (mode)
      MODE_8K:      base = 16'h1000;
      MODE_12K:     base = 16'h2000;
      MODE_32K:     base = 16'h7000;
      MODE_QUAD1K:  base = 16'h1c00;
      MODE_DATA2K:  base = 16'h1800;
      MODE_TWOBANK: base = 16'h1000;
      MODE_RAM2K:   base = 16'h3800;
      default:      base = 16'h0000;
    endcase
    return base;
  endfunction

  // number of slots splitting the 0x1000-0x1FFF window
  function automatic logic [2:0] mode_slots(input logic [3:0] mode);
    logic [2:0] n;
    unique case (mode)
      MODE_2K, MODE_DATA2K, MODE_RAM2K, MODE_RAM1K: n = 3'd2;
      MODE_QUAD1K:                                  n = 3'd4;
      default:                                      n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// File: design/cartridge_bank_switch_mapper.sv
// Cartridge bank-switch mapper. Each request is one 13-bit CPU bus access and
// yields one result: no response (also for hotspots), a ROM read offset, an
// extra-RAM read or write offset, or the bank-counter read of counting mode.
// One request is accepted every clock while in_stall is low; a request sits in the
// input register, where the decode and the slot/page/counter updates happen, and
// its result is then held in the result register. A hotspot's update is visible to
// the very next request. Mode writes on the configuration port reload the slot
// bases, RAM page and bank counter; the port is always ready and must only be used
// while no request is in flight.
`include "cartridge_bank_switch_mapper_defines.svh"

module cartridge_bank_switch_mapper #(
  parameter int ROM_ADDR_BITS = cbsm_pkg::ROM_ADDR_BITS_DEF,
  parameter int RAM_BYTES     = cbsm_pkg::RAM_BYTES_DEF,
  parameter int SLOT_COUNT    = cbsm_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cbsm_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cbsm_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [1:0]  LAST_SLOT = 2'(SLOT_COUNT - 1);
  localparam logic [15:0] ROM_MASK  = 16'((32'd1 << ROM_ADDR_BITS) - 32'd1);
  localparam logic [15:0] RESET_BASE = cbsm_pkg::mode_init(cbsm_pkg::MODE_4K);

  // request pipeline
  logic           in_valid_r, in_valid_nxt;
  cbsm_pkg::in_t  in_data_r, in_data_nxt;
  logic           out_valid_r, out_valid_nxt;
  cbsm_pkg::out_t out_data_r, out_data_nxt;
  logic           accept, advance, cfg_we;

  // mapper state
  logic [3:0]               bank_mode_r, bank_mode_nxt;
  logic                     extra_ram_on_r, extra_ram_on_nxt;
  logic [ROM_ADDR_BITS-1:0] slot_base_r [SLOT_COUNT];
  logic [ROM_ADDR_BITS-1:0] slot_base_nxt [SLOT_COUNT];
  logic [2:0]               ram_page_r, ram_page_nxt;
  logic [3:0]               bank_counter_r, bank_counter_nxt;
  logic [15:0]              init_base;

  // decode
  logic [3:0]     mode_eff;
  logic [12:0]    a;
  logic           w;
  logic [7:0]     d;
  cbsm_pkg::out_t res;
  logic           sh_en;
  logic [12:0]    sh_lo, sh_hi, sh_diff, q_off;
  logic [3:0]     cnt_inc;
  logic [2:0]     nslots;
  logic [1:0]     rom_sel;
  logic [15:0]    rom_ofs, rom_sum;
  logic           slot_we, page_we, cnt_we;
  logic [1:0]     slot_sel;
  logic [15:0]    slot_wdata;
  logic [2:0]     page_wdata;

  // assertion terms
  logic           mem_tgt, cnt_tgt, mode_we, start_vals;

  // x mod RAM_BYTES for x below 2048 and RAM_BYTES of at least 256
  function automatic logic [10:0] ram_mod(input logic [10:0] x);
    logic [13:0] r;
    r = 14'(x);
    for (int k = 2; k >= 0; k--) begin
      if (r >= (14'(RAM_BYTES) << k)) begin
        r = r - (14'(RAM_BYTES) << k);
      end
    end
    return r[10:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_data_nxt   = in_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (advance) begin
      in_valid_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
    if (accept) begin
      in_valid_nxt = 1'b1;
      in_data_nxt  = in_data;
    end
  end

  always_comb begin
    mode_eff = (bank_mode_r > cbsm_pkg::MODE_RAM1K) ? cbsm_pkg::MODE_4K : bank_mode_r;
    a = in_data_r.address;
    w = in_data_r.is_write;
    d = in_data_r.write_data;

    res        = '0;
    slot_we    = 1'b0;
    slot_sel   = '0;
    slot_wdata = '0;
    page_we    = 1'b0;
    page_wdata = ram_page_r;
    cnt_we     = 1'b0;

    // 4K-bank hotspot ranges
    sh_en = 1'b1;
    sh_lo = 13'h1ff8;
    sh_hi = 13'h1ff9;
    unique case (mode_eff)
      cbsm_pkg::MODE_8K:  sh_hi = 13'h1ff9;
      cbsm_pkg::MODE_12K: sh_hi = 13'h1ffa;
      cbsm_pkg::MODE_16K: sh_lo = 13'h1ff6;
      cbsm_pkg::MODE_32K: begin
        sh_lo = 13'h1ff4;
        sh_hi = 13'h1ffb;
      end
      default: sh_en = 1'b0;
    endcase
    sh_diff = a - sh_lo;
    q_off   = a - 13'h1fe0;
    cnt_inc = bank_counter_r + 4'd1;

    // ROM slot select from the window split
    nslots = cbsm_pkg::mode_slots(mode_eff);
    unique case (nslots)
      3'd4: begin
        rom_sel = a[11:10];
        rom_ofs = {6'b0, a[9:0]};
      end
      3'd2: begin
        rom_sel = {1'b0, a[11]};
        rom_ofs = {5'b0, a[10:0]};
      end
      default: begin
        rom_sel = 2'd0;
        rom_ofs = {4'b0, a[11:0]};
      end
    endcase
    if (rom_sel > LAST_SLOT) begin
      rom_sel = LAST_SLOT;
    end
    rom_sum = 16'(slot_base_r[rom_sel[SLOT_W-1:0]]) + rom_ofs;

    if (extra_ram_on_r && w && a >= 13'h1000 && a <= 13'h107f) begin
      res.target        = cbsm_pkg::TGT_RAM_WR;
      res.target_offset = 16'(ram_mod({4'b0, a[6:0]}));
    end else if (extra_ram_on_r && !w && a >= 13'h1080 && a <= 13'h10ff) begin
      res.target        = cbsm_pkg::TGT_RAM_RD;
      res.target_offset = 16'(ram_mod({4'b0, a[6:0]}));
    end else if (mode_eff == cbsm_pkg::MODE_12K && w && a >= 13'h1000 && a <= 13'h10ff) begin
      res.target        = cbsm_pkg::TGT_RAM_WR;
      res.target_offset = 16'(ram_mod({3'b0, a[7:0]}));
    end else if (mode_eff == cbsm_pkg::MODE_12K && !w && a >= 13'h1100 && a <= 13'h11ff) begin
      res.target        = cbsm_pkg::TGT_RAM_RD;
      res.target_offset = 16'(ram_mod({3'b0, a[7:0]}));
    end else if (mode_eff == cbsm_pkg::MODE_RAM1K && w && a >= 13'h1400 && a <= 13'h17ff) begin
      res.target        = cbsm_pkg::TGT_RAM_WR;
      res.target_offset = 16'(ram_mod({1'b0, a[9:0]}));
    end else if (mode_eff == cbsm_pkg::MODE_RAM1K && !w && a >= 13'h1000 && a <= 13'h13ff) begin
      res.target        = cbsm_pkg::TGT_RAM_RD;
      res.target_offset = 16'(ram_mod({1'b0, a[9:0]}));
    end else if (sh_en && a >= sh_lo && a <= sh_hi) begin
      slot_we    = 1'b1;
      slot_wdata = {1'b0, sh_diff[2:0], 12'b0};
    end else if (mode_eff == cbsm_pkg::MODE_QUAD1K && a >= 13'h1fe0 && a <= 13'h1ff7) begin
      slot_we    = 1'b1;
      slot_sel   = q_off[4:3];
      slot_wdata = {3'b0, q_off[2:0], 10'b0};
    end else if (mode_eff == cbsm_pkg::MODE_DATA2K && w && a <= 13'h003f) begin
      slot_we    = 1'b1;
      slot_wdata = {3'b0, d[1:0], 11'b0};
    end else if (mode_eff == cbsm_pkg::MODE_TWOBANK && a >= 13'h0200 && a <= 13'h027f) begin
      slot_we    = 1'b1;
      slot_wdata = {3'b0, a[6], 12'b0};
    end else if (mode_eff == cbsm_pkg::MODE_RAM2K && a >= 13'h1fe0 && a <= 13'h1fe7) begin
      slot_we    = 1'b1;
      slot_wdata = {2'b0, a[2:0], 11'b0};
    end else if (mode_eff == cbsm_pkg::MODE_RAM2K && a >= 13'h1fe8 && a <= 13'h1feb) begin
      page_we    = 1'b1;
      page_wdata = {1'b1, a[1:0]};
    end else if (mode_eff == cbsm_pkg::MODE_RAM2K && w && a >= 13'h1800 && a <= 13'h18ff) begin
      res.target        = cbsm_pkg::TGT_RAM_WR;
      res.target_offset = 16'(ram_mod({ram_page_r, a[7:0]}));
    end else if (mode_eff == cbsm_pkg::MODE_RAM2K && !w && a >= 13'h1900 && a <= 13'h19ff) begin
      res.target        = cbsm_pkg::TGT_RAM_RD;
      res.target_offset = 16'(ram_mod({ram_page_r, a[7:0]}));
    end else if (mode_eff == cbsm_pkg::MODE_COUNTER && a == 13'h1ff0) begin
      cnt_we     = 1'b1;
      slot_we    = 1'b1;
      slot_wdata = {cnt_inc, 12'b0};
    end else if (mode_eff == cbsm_pkg::MODE_COUNTER && !w && a == 13'h1fec) begin
      res.target        = cbsm_pkg::TGT_COUNTER;
      res.counter_value = bank_counter_r;
    end else if (!w && a >= 13'h1000) begin
      res.target        = cbsm_pkg::TGT_ROM_RD;
      res.target_offset = rom_sum & ROM_MASK;
    end
  end

  always_comb begin
    init_base        = cbsm_pkg::mode_init(cfg_data);
    bank_mode_nxt    = bank_mode_r;
    extra_ram_on_nxt = extra_ram_on_r;
    ram_page_nxt     = ram_page_r;
    bank_counter_nxt = bank_counter_r;
    slot_base_nxt    = slot_base_r;
    if (cfg_we && cfg_index == cbsm_pkg::CFG_BANK_MODE) begin
      // mode change: reload start values
      bank_mode_nxt    = cfg_data;
      ram_page_nxt     = cbsm_pkg::RAM_PAGE_START;
      bank_counter_nxt = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_base_nxt[i] = init_base[ROM_ADDR_BITS-1:0];
      end
    end else if (advance) begin
      if (page_we) begin
        ram_page_nxt = page_wdata;
      end
      if (cnt_we) begin
        bank_counter_nxt = cnt_inc;
      end
      // slots past SLOT_COUNT never match: drop those updates
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_we && slot_sel == 2'(i)) begin
          slot_base_nxt[i] = slot_wdata[ROM_ADDR_BITS-1:0];
        end
      end
    end
    if (cfg_we && cfg_index == cbsm_pkg::CFG_EXTRA_RAM) begin
      extra_ram_on_nxt = cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      bank_mode_r    <= cbsm_pkg::MODE_4K;
      extra_ram_on_r <= 1'b0;
      ram_page_r     <= cbsm_pkg::RAM_PAGE_START;
      bank_counter_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_base_r[i] <= RESET_BASE[ROM_ADDR_BITS-1:0];
      end
    end else begin
      in_valid_r     <= in_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      bank_mode_r    <= bank_mode_nxt;
      extra_ram_on_r <= extra_ram_on_nxt;
      ram_page_r     <= ram_page_nxt;
      bank_counter_r <= bank_counter_nxt;
      slot_base_r    <= slot_base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign mem_tgt    = out_data.target inside {cbsm_pkg::TGT_ROM_RD, cbsm_pkg::TGT_RAM_RD,
                                              cbsm_pkg::TGT_RAM_WR};
  assign cnt_tgt    = out_data.target == cbsm_pkg::TGT_COUNTER;
  assign mode_we    = cfg_we && cfg_index == cbsm_pkg::CFG_BANK_MODE;
  assign start_vals = ram_page_r == cbsm_pkg::RAM_PAGE_START && bank_counter_r == '0;

  `CBSM_ASSERT_NOW(a_ofs_zero, out_valid && !mem_tgt, out_data.target_offset == '0, "stray offset")
  `CBSM_ASSERT_NOW(a_count_zero, out_valid && !cnt_tgt, out_data.counter_value == '0, "stray count")
  `CBSM_ASSERT_NOW(a_stall_cause, in_stall, in_valid_r && out_valid_r && out_stall, "bad stall")
  `CBSM_ASSERT_NEXT(a_mode_reload, mode_we, start_vals, "no reload on mode write")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 48;
  localparam int PHASE_ITEMS = 64;

  typedef struct packed {
    logic [3:0]     mode;
    logic           xram;
    cbsm_pkg::in_t  req;
    logic           typed;
    cbsm_pkg::out_t want;
  } directed_row_t;

  // mode, extra RAM, {address, write, data}, typed, {target, offset, counter}
  localparam directed_row_t DIRECTED [27] = '{
    {cbsm_pkg::MODE_4K,      1'b0, 13'h1000, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_ROM_RD,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_4K,      1'b0, 13'h1fff, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_ROM_RD,
     16'h0fff, 4'd0},
    {cbsm_pkg::MODE_4K,      1'b0, 13'h1fff, 1'b1, 8'hff, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_4K,      1'b1, 13'h1000, 1'b1, 8'h00, 1'b1, cbsm_pkg::TGT_RAM_WR,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_4K,      1'b1, 13'h10ff, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_RAM_RD,
     16'h007f, 4'd0},
    {cbsm_pkg::MODE_12K,     1'b1, 13'h10c0, 1'b1, 8'h5a, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_12K,     1'b1, 13'h1ffa, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_12K,     1'b1, 13'h1234, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_32K,     1'b0, 13'h1ffb, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_32K,     1'b0, 13'h1abc, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_QUAD1K,  1'b0, 13'h1ff7, 1'b1, 8'h00, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_QUAD1K,  1'b0, 13'h1fff, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_QUAD1K,  1'b0, 13'h1ff8, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_DATA2K,  1'b0, 13'h0010, 1'b0, 8'h03, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_DATA2K,  1'b0, 13'h003f, 1'b1, 8'hff, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_DATA2K,  1'b0, 13'h1000, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_TWOBANK, 1'b0, 13'h0240, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_TWOBANK, 1'b0, 13'h1800, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_RAM2K,   1'b0, 13'h18ff, 1'b1, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_RAM2K,   1'b0, 13'h1feb, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_RAM2K,   1'b0, 13'h19ff, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_COUNTER, 1'b0, 13'h1fec, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_COUNTER,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_COUNTER, 1'b0, 13'h1ff0, 1'b1, 8'h00, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_COUNTER, 1'b0, 13'h1fec, 1'b0, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_COUNTER, 1'b0, 13'h1fec, 1'b1, 8'h00, 1'b1, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {cbsm_pkg::MODE_RAM1K,   1'b0, 13'h17ff, 1'b1, 8'h00, 1'b0, cbsm_pkg::TGT_NONE,
     16'h0000, 4'd0},
    {4'd15,                  1'b0, 13'h1fff, 1'b0, 8'h00, 1'b1, cbsm_pkg::TGT_ROM_RD,
     16'h0fff, 4'd0}
  };

  localparam logic [15:0] START_BASE [16] = '{
    16'h0000, 16'h0000, 16'h1000, 16'h2000, 16'h0000, 16'h7000, 16'h0000, 16'h1c00,
    16'h1800, 16'h1000, 16'h3800, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };
  localparam int SLOT_SPLIT [16] = '{2, 1, 1, 1, 1, 1, 1, 4, 2, 1, 2, 1, 2, 1, 1, 1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid;
  logic in_stall;
  cbsm_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  cbsm_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [cbsm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cbsm_pkg::CFG_DATA_W-1:0] cfg_data;

  // mapper state as the predictor sees it
  logic [3:0]  cur_mode;
  logic        xram_on;
  logic [15:0] bank_base [4];
  logic [2:0]  ram_bank;
  logic [3:0]  step_count;

  cbsm_pkg::out_t predicted_responses [$];
  int   field_errors = 0;
  bit   calm = 1'b0;
  int   holds_asked = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  cartridge_bank_switch_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reload_banks();
    ram_bank = cbsm_pkg::RAM_PAGE_START;
    step_count = 4'd0;
    for (int i = 0; i < 4; i++) begin
      bank_base[i] = START_BASE[cur_mode];
    end
  endfunction

  // decode one bus access and apply any bank switch it triggers
  function automatic cbsm_pkg::out_t map_access(cbsm_pkg::in_t req);
    cbsm_pkg::out_t res;
    logic [3:0]     m;
    logic [12:0]    a;
    logic [12:0]    lo;
    logic [12:0]    hi;
    int unsigned    sz;
    int unsigned    sel;
    res = '0;
    a = req.address;
    m = (cur_mode > cbsm_pkg::MODE_RAM1K) ? cbsm_pkg::MODE_4K : cur_mode;
    if (xram_on) begin
      if (req.is_write && a >= 13'h1000 && a <= 13'h107f) begin
        res.target = cbsm_pkg::TGT_RAM_WR;
        res.target_offset = 16'(a[6:0]);
        return res;
      end
      if (!req.is_write && a >= 13'h1080 && a <= 13'h10ff) begin
        res.target = cbsm_pkg::TGT_RAM_RD;
        res.target_offset = 16'(a[6:0]);
        return res;
      end
    end
    if (m == cbsm_pkg::MODE_12K) begin
      if (req.is_write && a >= 13'h1000 && a <= 13'h10ff) begin
        res.target = cbsm_pkg::TGT_RAM_WR;
        res.target_offset = 16'(a[7:0]);
        return res;
      end
      if (!req.is_write && a >= 13'h1100 && a <= 13'h11ff) begin
        res.target = cbsm_pkg::TGT_RAM_RD;
        res.target_offset = 16'(a[7:0]);
        return res;
      end
    end
    if (m == cbsm_pkg::MODE_RAM1K) begin
      if (req.is_write && a >= 13'h1400 && a <= 13'h17ff) begin
        res.target = cbsm_pkg::TGT_RAM_WR;
        res.target_offset = 16'(a[9:0]);
        return res;
      end
      if (!req.is_write && a >= 13'h1000 && a <= 13'h13ff) begin
        res.target = cbsm_pkg::TGT_RAM_RD;
        res.target_offset = 16'(a[9:0]);
        return res;
      end
    end

    lo = '0;
    hi = '0;
    case (m)
      cbsm_pkg::MODE_8K: begin
        lo = 13'h1ff8;
        hi = 13'h1ff9;
      end
      cbsm_pkg::MODE_12K: begin
        lo = 13'h1ff8;
        hi = 13'h1ffa;
      end
      cbsm_pkg::MODE_16K: begin
        lo = 13'h1ff6;
        hi = 13'h1ff9;
      end
      cbsm_pkg::MODE_32K: begin
        lo = 13'h1ff4;
        hi = 13'h1ffb;
      end
      default: ;
    endcase
    if (hi != '0 && a >= lo && a <= hi) begin
      bank_base[0] = 16'(a - lo) << 12;
      return res;
    end

    if (m == cbsm_pkg::MODE_QUAD1K && a >= 13'h1fe0 && a <= 13'h1ff7) begin
      sel = a - 13'h1fe0;
      bank_base[sel >> 3] = 16'((sel & 7) * 16'h0400);
      return res;
    end
    if (m == cbsm_pkg::MODE_DATA2K && req.is_write && a <= 13'h003f) begin
      bank_base[0] = 16'(req.write_data[1:0]) << 11;
      return res;
    end
    if (m == cbsm_pkg::MODE_TWOBANK && a >= 13'h0200 && a <= 13'h027f) begin
      bank_base[0] = 16'((a - 13'h0200) >> 6) << 12;
      return res;
    end
    if (m == cbsm_pkg::MODE_RAM2K) begin
      if (a >= 13'h1fe0 && a <= 13'h1fe7) begin
        bank_base[0] = 16'(a - 13'h1fe0) << 11;
        return res;
      end
      if (a >= 13'h1fe8 && a <= 13'h1feb) begin
        ram_bank = 3'(cbsm_pkg::RAM_PAGE_START + (a - 13'h1fe8));
        return res;
      end
      if (req.is_write && a >= 13'h1800 && a <= 13'h18ff) begin
        res.target = cbsm_pkg::TGT_RAM_WR;
        res.target_offset = 16'({ram_bank, a[7:0]});
        return res;
      end
      if (!req.is_write && a >= 13'h1900 && a <= 13'h19ff) begin
        res.target = cbsm_pkg::TGT_RAM_RD;
        res.target_offset = 16'({ram_bank, a[7:0]});
        return res;
      end
    end
    if (m == cbsm_pkg::MODE_COUNTER) begin
      if (a == 13'h1ff0) begin
        step_count = step_count + 4'd1;
        bank_base[0] = 16'(step_count) << 12;
        return res;
      end
      if (a == 13'h1fec && !req.is_write) begin
        res.target = cbsm_pkg::TGT_COUNTER;
        res.counter_value = step_count;
        return res;
      end
    end

    if (!req.is_write && a >= 13'h1000) begin
      sz = 4096 / SLOT_SPLIT[m];
      sel = a[11:0] / sz;
      if (sel > 3) sel = 3;
      res.target = cbsm_pkg::TGT_ROM_RD;
      res.target_offset = bank_base[sel] + 16'(a[11:0] % sz);
    end
    return res;
  endfunction

  task automatic offer_access(cbsm_pkg::in_t req, logic typed, cbsm_pkg::out_t want);
    cbsm_pkg::out_t guess;
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    guess = map_access(req);
    predicted_responses.push_back(typed ? want : guess);
  endtask

  // drop valid and wait until the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(logic [3:0] mode, logic xram);
    cfg_valid <= 1'b1;
    cfg_index <= cbsm_pkg::CFG_BANK_MODE;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = mode;
    reload_banks();
    cfg_index <= cbsm_pkg::CFG_EXTRA_RAM;
    cfg_data <= {3'b000, xram};
    do @(posedge clk); while (!cfg_ready);
    xram_on = xram;
    cfg_valid <= 1'b0;
  endtask

  // result side: check, then pick the next stall
  always @(posedge clk) begin : result_check
    cbsm_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_responses.size() == 0) begin
        $error("unexpected result: target %0d offset 0x%04h", out_data.target,
               out_data.target_offset);
        field_errors++;
      end else begin
        want = predicted_responses.pop_front();
        if (out_data.target !== want.target) begin
          $error("target: expected %0d, got %0d", want.target, out_data.target);
          field_errors++;
        end
        if (out_data.target_offset !== want.target_offset) begin
          $error("target_offset: expected 0x%04h, got 0x%04h", want.target_offset,
                 out_data.target_offset);
          field_errors++;
        end
        if (out_data.counter_value !== want.counter_value) begin
          $error("counter_value: expected %0d, got %0d", want.counter_value,
                 out_data.counter_value);
          field_errors++;
        end
      end
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    cbsm_pkg::in_t req;
    int            bucket;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_mode = cbsm_pkg::MODE_4K;
    xram_on = 1'b0;
    reload_banks();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].mode != cur_mode || DIRECTED[r].xram != xram_on) begin
        settle();
        apply_setting(DIRECTED[r].mode, DIRECTED[r].xram);
      end
      offer_access(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // one phase per mode value, undefined codes included
    for (int p = 0; p < 16; p++) begin
      settle();
      apply_setting(4'(p), 1'($urandom_range(1)));
      calm = (p == 5);
      // stall the result side for a long stretch while requests keep coming
      if (p == 5) holds_asked++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        bucket = $urandom_range(99);
        req.write_data = 8'($urandom_range(255));
        req.is_write = ($urandom_range(99) < 40);
        if (bucket < 30) begin
          req.address = 13'h1fe0 + 13'($urandom_range(31));
        end else if (bucket < 36) begin
          req.address = $urandom_range(1) ? 13'h1ff0 : 13'h1fec;
        end else if (bucket < 66) begin
          req.address = 13'h1000 + 13'($urandom_range(4095));
          req.is_write = ($urandom_range(9) == 0);
        end else if (bucket < 80) begin
          req.address = 13'h1000 + 13'($urandom_range(13'h09ff));
        end else if (bucket < 90) begin
          req.address = 13'($urandom_range(13'h027f));
        end else begin
          req.address = 13'($urandom());
        end
        offer_access(req, 1'b0, '0);
      end
      calm = 1'b0;
    end

    settle();
    if (field_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
